@@ sv/atws_pkg.sv @@
// Shared types and constants for the asymmetric triangle wave sample generator.
package atws_pkg;

  localparam int IDX_W   = 12;  // sample index
  localparam int PTS_W   = 13;  // point count, rise length, divisor
  localparam int PEAK_W  = 16;  // peak value, quotient
  localparam int DUTY_W  = 7;   // duty in percent
  localparam int PROD_W  = PTS_W + DUTY_W;   // duty * points
  localparam int NUM_W   = PEAK_W + PTS_W;   // peak * factor
  localparam int QUO_W   = PEAK_W;           // quotient bits, one per cell
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  // floor(x / 100) = (x * RECIP) >> RECIP_SHIFT, exact for x < 2**PROD_W
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP = 21'd1342178;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY   = 2'd2;

  localparam logic [PEAK_W-1:0] PEAK_RST   = 16'd4095;
  localparam logic [PTS_W-1:0]  POINTS_RST = 13'd256;
  localparam logic [DUTY_W-1:0] DUTY_RST   = 7'd50;

  // Word handed from cell to cell in the divider chain.
  // rem: partial remainder, low: remaining dividend bits shifting out while
  // quotient bits shift in.
  typedef struct packed {
    logic [PTS_W-1:0]  rem;
    logic [QUO_W-1:0]  low;
    logic [PTS_W-1:0]  denom;
    logic              index_valid;
  } div_word_t;

endpackage

@@ sv/asymmetric_triangle_wave_sample.sv @@
// Pipeline: a transaction accepted on the input passes through 4 front stages, then one
//   cell per quotient bit of the 16-cell divider chain, before it appears on the output.
// Throughput: one transaction per cycle while out_ready holds; each stage holds only
//   while the one after it is full and stalled, so bubbles are squeezed out.
// Reset (rst, synchronous): pipeline emptied, registers back to peak 4095,
//   256 points, 50 % duty.
module asymmetric_triangle_wave_sample #(
  parameter int MAX_POINTS  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             wr_en,
  input  logic [atws_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [atws_pkg::CFG_W-1:0]       wr_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [atws_pkg::IDX_W-1:0]       sample_index,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [atws_pkg::PEAK_W-1:0]      sample_value,
  output logic                             index_valid
);

  localparam int CELLS = atws_pkg::QUO_W;
  // quotient is masked down to SAMPLE_BITS before leaving the block
  localparam logic [atws_pkg::PEAK_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= atws_pkg::PEAK_W) ? '1 :
    atws_pkg::PEAK_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [atws_pkg::PEAK_W-1:0] peak_value;
  logic [atws_pkg::PTS_W-1:0]  point_count;
  logic [atws_pkg::DUTY_W-1:0] duty_percent;

  // handshake and data between the front stages and along the cell chain
  logic [CELLS:0]       chain_vld;
  logic [CELLS:0]       chain_rdy;
  atws_pkg::div_word_t  chain_data [CELLS+1];

  // Config registers: writes to unknown indexes are dropped. The user must write only
  // with the pipeline empty; the block does not enforce it. Stages read these live.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_value   <= atws_pkg::PEAK_RST;
      point_count  <= atws_pkg::POINTS_RST;
      duty_percent <= atws_pkg::DUTY_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        atws_pkg::REG_PEAK:   peak_value   <= wr_data;
        atws_pkg::REG_POINTS: point_count  <= wr_data[atws_pkg::PTS_W-1:0];
        atws_pkg::REG_DUTY:   duty_percent <= wr_data[atws_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: rise = duty*points/100, choose rising or falling ramp,
  // form dividend peak*factor and divisor.
  atws_prep #(
    .MAX_POINTS (MAX_POINTS)
  ) u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_index (sample_index),
    .peak_value   (peak_value),
    .point_count  (point_count),
    .duty_percent (duty_percent),
    .out_valid    (chain_vld[0]),
    .out_ready    (chain_rdy[0]),
    .out_data     (chain_data[0])
  );

  // Divider chain, MSB of the quotient first. Quotient never exceeds the
  // peak, so 16 cells cover it.
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    atws_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (chain_vld[g]),
      .up_ready   (chain_rdy[g]),
      .up_data    (chain_data[g]),
      .down_valid (chain_vld[g+1]),
      .down_ready (chain_rdy[g+1]),
      .down_data  (chain_data[g+1])
    );
  end

  assign chain_rdy[CELLS] = out_ready;
  assign out_valid        = chain_vld[CELLS];
  // invalid indexes were turned into 0 / 1 upstream, so quotient is already zero
  assign sample_value     = chain_data[CELLS].low & SAMPLE_MASK;
  assign index_valid      = chain_data[CELLS].index_valid;

`ifndef SYNTHESIS
  // an out-of-range index must come back as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !index_valid |-> sample_value == '0)
    else $error("invalid index produced nonzero sample");

  // reset empties the whole chain
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending straight after reset");

  // with nothing waiting at the output the ready chain must reach the input
  a_ready_ripple: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");
`endif

endmodule

@@ sv/atws_prep.sv @@
// Front stages: rise length, ramp selection and dividend product.
module atws_prep #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [atws_pkg::IDX_W-1:0]    sample_index,
  input  logic [atws_pkg::PEAK_W-1:0]   peak_value,
  input  logic [atws_pkg::PTS_W-1:0]    point_count,
  input  logic [atws_pkg::DUTY_W-1:0]   duty_percent,
  output logic                          out_valid,
  input  logic                          out_ready,
  output atws_pkg::div_word_t           out_data
);

  localparam logic [31:0] MAX_P = 32'(MAX_POINTS);

  logic [atws_pkg::PTS_W-1:0]  pts_eff;
  logic [atws_pkg::DUTY_W-1:0] duty_eff;

  // stage A
  logic                         a_vld;
  logic [atws_pkg::IDX_W-1:0]   a_idx;
  logic [atws_pkg::PROD_W-1:0]  a_prod;
  logic                         a_ok;
  // stage B
  logic                         b_vld;
  logic [atws_pkg::IDX_W-1:0]   b_idx;
  logic [atws_pkg::PTS_W-1:0]   b_rise;
  logic                         b_ok;
  // stage C
  logic                         c_vld;
  logic [atws_pkg::PTS_W-1:0]   c_fac;
  logic [atws_pkg::PTS_W-1:0]   c_den;
  logic                         c_ok;
  // stage D
  logic                         d_vld;
  atws_pkg::div_word_t          d_data;

  logic a_adv, b_adv, c_adv, d_adv;
  logic [atws_pkg::PROD_W+atws_pkg::RECIP_W-1:0] rise_mul;
  logic                        rising;
  logic [atws_pkg::PTS_W-1:0]  fac_next, den_next;
  logic [atws_pkg::NUM_W-1:0]  num_next;

  assign pts_eff  = (32'(point_count) > MAX_P) ? MAX_P[atws_pkg::PTS_W-1:0] : point_count;
  assign duty_eff = (duty_percent > atws_pkg::DUTY_MAX) ? atws_pkg::DUTY_MAX : duty_percent;

  assign d_adv    = !d_vld || out_ready;
  assign c_adv    = !c_vld || d_adv;
  assign b_adv    = !b_vld || c_adv;
  assign a_adv    = !a_vld || b_adv;
  assign in_ready = a_adv;

  assign rise_mul = a_prod * atws_pkg::RECIP;
  assign rising   = {1'b0, b_idx} < b_rise;

  always_comb begin
    if (!b_ok) begin
      fac_next = '0;
      den_next = atws_pkg::PTS_W'(1);
    end else if (rising) begin
      fac_next = {1'b0, b_idx};
      den_next = b_rise;
    end else begin
      fac_next = pts_eff - {1'b0, b_idx};
      den_next = pts_eff - b_rise;
    end
  end

  assign num_next = peak_value * c_fac;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
    end else begin
      if (a_adv) a_vld <= in_valid;
      if (b_adv) b_vld <= a_vld;
      if (c_adv) c_vld <= b_vld;
      if (d_adv) d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      a_idx  <= sample_index;
      a_prod <= duty_eff * pts_eff;
      a_ok   <= {1'b0, sample_index} < pts_eff;
    end
    if (b_adv && a_vld) begin
      b_idx  <= a_idx;
      b_rise <= rise_mul[atws_pkg::RECIP_SHIFT +: atws_pkg::PTS_W];
      b_ok   <= a_ok;
    end
    if (c_adv && b_vld) begin
      c_fac <= fac_next;
      c_den <= den_next;
      c_ok  <= b_ok;
    end
    if (d_adv && c_vld) begin
      d_data.rem         <= num_next[atws_pkg::NUM_W-1 -: atws_pkg::PTS_W];
      d_data.low         <= num_next[atws_pkg::QUO_W-1:0];
      d_data.denom       <= c_den;
      d_data.index_valid <= c_ok;
    end
  end

  assign out_valid = d_vld;
  assign out_data  = d_data;

endmodule

@@ sv/atws_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit per pass.
module atws_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  atws_pkg::div_word_t  up_data,
  output logic                 down_valid,
  input  logic                 down_ready,
  output atws_pkg::div_word_t  down_data
);

  logic                        vld;
  atws_pkg::div_word_t         data;
  logic                        adv;
  logic [atws_pkg::PTS_W:0]    trial;
  logic [atws_pkg::PTS_W:0]    diff;
  logic                        ge;
  atws_pkg::div_word_t         data_next;

  assign adv   = !vld || down_ready;
  assign trial = {up_data.rem, up_data.low[atws_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, up_data.denom};
  assign ge    = trial >= {1'b0, up_data.denom};

  always_comb begin
    data_next       = up_data;
    data_next.rem   = ge ? diff[atws_pkg::PTS_W-1:0] : trial[atws_pkg::PTS_W-1:0];
    data_next.low   = {up_data.low[atws_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      data <= data_next;
    end
  end

  assign up_ready   = adv;
  assign down_valid = vld;
  assign down_data  = data;

endmodule

@@ verif/tb_asymmetric_triangle_wave_sample.sv @@
// Self-checking testbench for the asymmetric triangle wave sample generator.
`timescale 1ns / 100ps

module tb_asymmetric_triangle_wave_sample;
  import atws_pkg::*;

  localparam int MAX_POINTS  = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int PERCENT     = 100;            // duty is given in percent
  localparam int PIPE_LATENCY = 20;            // input to output, through the front stages and divider cells
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 5;
  localparam int LONG_HOLD = 200;              // receiver back-pressure stretch, in cycles
  localparam int RANDOM_PHASES = 16;
  localparam int ITEMS_PER_PHASE = 102;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // no register behind this index

  // Predicted wave samples for accepted requests, in request order.
  class wave_ledger;
    typedef struct packed {
      logic [PEAK_W-1:0] value;
      logic              valid;
    } sample_t;

    bit [PEAK_W-1:0] peak;
    bit [PTS_W-1:0]  points;
    bit [DUTY_W-1:0] duty;
    sample_t expected_samples[$];
    int unsigned requests, beyond_range, results, mismatches;

    function new();
      peak   = PEAK_RST;
      points = POINTS_RST;
      duty   = DUTY_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_PEAK:   peak   = data[PEAK_W-1:0];
        REG_POINTS: points = data[PTS_W-1:0];
        REG_DUTY:   duty   = data[DUTY_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    endfunction

    // Point count and duty saturate before the rise length is formed.
    function longint unsigned effective_points();
      return (points > MAX_POINTS) ? longint'(MAX_POINTS) : longint'(points);
    endfunction

    function longint unsigned rise_length();
      longint unsigned pct;
      pct = (duty > DUTY_MAX) ? longint'(DUTY_MAX) : longint'(duty);
      return pct * effective_points() / PERCENT;
    endfunction

    function sample_t wave_at(logic [IDX_W-1:0] idx);
      longint unsigned pts, rise, quo;
      sample_t s;
      pts  = effective_points();
      rise = rise_length();
      quo  = 0;
      s.valid = (longint'(idx) < pts);
      if (s.valid) begin
        if (longint'(idx) < rise) begin
          quo = longint'(peak) * longint'(idx) / rise;
        end else begin
          quo = longint'(peak) * (pts - longint'(idx)) / (pts - rise);
        end
      end
      quo &= (64'd1 << SAMPLE_BITS) - 64'd1;
      s.value = quo[PEAK_W-1:0];
      return s;
    endfunction

    function void note_request(logic [IDX_W-1:0] idx);
      sample_t s;
      s = wave_at(idx);
      requests++;
      if (!s.valid) beyond_range++;
      expected_samples.push_back(s);
    endfunction

    function void check_result(logic [PEAK_W-1:0] value, logic valid);
      sample_t want;
      results++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %0d arrived with no request outstanding (value %0d, valid %0b)",
                   $realtime, results, value, valid);
        return;
      end
      want = expected_samples.pop_front();
      if (value !== want.value || valid !== want.valid) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %0d: sample_value exp %0d got %0d, index_valid exp %0b got %0b",
                   $realtime, results, want.value, value, want.valid, valid);
      end
    endfunction

    function int unsigned pending();
      return expected_samples.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;
  logic in_valid, in_ready;
  logic [IDX_W-1:0] sample_index;
  logic out_valid, out_ready;
  logic [PEAK_W-1:0] sample_value;
  logic index_valid;

  wave_ledger board = new();
  bit calm;            // both sides run without random idle cycles
  bit hold_off_now;    // asks the receiver for one long back-pressure stretch
  int unsigned settings_seen;

  asymmetric_triangle_wave_sample #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_index (sample_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .index_valid  (index_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register write: the shadow copy is updated at the edge that takes it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Only called with the pipeline empty.
  task automatic apply_settings(input logic [CFG_W-1:0] peak_data,
                                input logic [CFG_W-1:0] points_data,
                                input logic [CFG_W-1:0] duty_data,
                                input bit poke_unused);
    write_reg(REG_PEAK, peak_data);
    write_reg(REG_POINTS, points_data);
    if (poke_unused) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
    write_reg(REG_DUTY, duty_data);
    @(negedge clk);
    wr_en <= 1'b0;
    settings_seen++;
  endtask

  // One request transaction; valid stays up across back-to-back transactions.
  task automatic offer(input logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    sample_index <= idx;
    do @(posedge clk); while (!in_ready);
    board.note_request(idx);
  endtask

  // Drop valid, let every outstanding result come back, then a short pause.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Config draws lean on the extremes; unused high bits of the write data carry junk.
  function automatic logic [CFG_W-1:0] draw_peak();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] draw_points();
    logic [CFG_W-1:0] data;
    int unsigned pts;
    case ($urandom_range(0, 9))
      0:       pts = 1;
      1:       pts = 2;
      2:       pts = MAX_POINTS;
      3:       pts = 0;                                 // nothing valid
      4:       pts = $urandom_range(MAX_POINTS + 1, 8191);  // saturates
      5, 6:    pts = $urandom_range(3, 64);
      default: pts = $urandom_range(1, MAX_POINTS);
    endcase
    data = 16'($urandom_range(0, 65535));
    data[PTS_W-1:0] = pts[PTS_W-1:0];
    return data;
  endfunction

  function automatic logic [CFG_W-1:0] draw_duty();
    logic [CFG_W-1:0] data;
    int unsigned pct;
    case ($urandom_range(0, 7))
      0:       pct = 0;
      1:       pct = PERCENT;
      2:       pct = $urandom_range(PERCENT + 1, 127);   // saturates to full rise
      3:       pct = 1;
      4:       pct = PERCENT - 1;
      default: pct = $urandom_range(0, PERCENT);
    endcase
    data = 16'($urandom_range(0, 65535));
    data[DUTY_W-1:0] = pct[DUTY_W-1:0];
    return data;
  endfunction

  // Mostly in-range indices, with weight on the corner and the ends of the period.
  function automatic logic [IDX_W-1:0] pick_index();
    longint unsigned pts, rise, pick;
    pts  = board.effective_points();
    rise = board.rise_length();
    case ($urandom_range(0, 9))
      6:       pick = (rise == 0) ? 0 : rise - 1 + $urandom_range(0, 2);
      7:       pick = pts - 1 + $urandom_range(0, 1);
      8:       pick = $urandom_range(0, 1) ? 0 : 4095;
      9:       pick = $urandom_range(0, 4095);
      default: pick = (pts == 0) ? $urandom_range(0, 4095) : $urandom_range(0, pts - 1);
    endcase
    if (pick > 4095) pick = 4095;
    return pick[IDX_W-1:0];
  endfunction

  // Result side: random stalls, plus the occasional long hold that backs the pipe up.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_now) begin
        hold_off_now = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 6);
      end
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(sample_value, index_valid);
    end
  end

  initial begin
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = REG_PEAK;
    wr_data      = '0;
    in_valid     = 1'b0;
    sample_index = '0;
    calm         = 1'b0;
    hold_off_now = 1'b0;
    settings_seen = 1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: both ramp ends, the peak corner and just past the period.
    offer(12'd0);    offer(12'd1);    offer(12'd127);  offer(12'd128);
    offer(12'd129);  offer(12'd255);  offer(12'd256);  offer(12'd4095);
    settle();

    // Full-scale pure rising ramp.
    apply_settings(16'hFFFF, 16'd4096, 16'd100, 1'b0);
    offer(12'd0);  offer(12'd1);  offer(12'd4094);  offer(12'd4095);
    settle();

    // Full-scale pure falling ramp.
    apply_settings(16'hFFFF, 16'd4096, 16'd0, 1'b0);
    offer(12'd0);  offer(12'd4095);
    settle();

    // Empty period: nothing is a valid index.
    apply_settings(16'd1000, 16'd0, 16'd50, 1'b0);
    offer(12'd0);  offer(12'd4095);
    settle();

    // Point count and duty both past their limits, junk above the field widths.
    apply_settings(16'd777, 16'hFFFF, 16'hFFFF, 1'b0);
    offer(12'd4095);  offer(12'd0);  offer(12'd2047);
    settle();

    // Single-point period; a write to the unmapped index must change nothing.
    apply_settings(16'd500, 16'd1, 16'd50, 1'b1);
    offer(12'd0);  offer(12'd1);
    settle();

    // Random settings, each followed by a burst of requests.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p % 4 == 1);
      apply_settings(draw_peak(), draw_points(), draw_duty(), $urandom_range(0, 3) == 0);
      if (p == 2 || p == 9) hold_off_now = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) offer(pick_index());
      settle();
    end

    $display("Covered %0d requests over %0d register settings, %0d of them past the period.",
             board.requests, settings_seen, board.beyond_range);
    $display("Checked %0d results, %0d mismatches, %0d still outstanding.",
             board.results, board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", board.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
sv/atws_pkg.sv
sv/atws_prep.sv
sv/atws_div_cell.sv
sv/asymmetric_triangle_wave_sample.sv
verif/tb_asymmetric_triangle_wave_sample.sv
